/* hdl/cnms_pkg.sv */
package cnms_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
   localparam int MAG_BITS    = 11;
   localparam int GRAD_BITS   = 11;
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 12;
   localparam int MAX_HEIGHT  = 4095;
   localparam int MIN_SIZE    = 3;
   localparam int PEND_BITS   = $clog2(MAX_WIDTH + 2);
   localparam int PROD_BITS   = MAG_BITS + GRAD_BITS + 1;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from paddr[2]
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef logic [MAG_BITS-1:0]         mag_type;
   typedef logic signed [GRAD_BITS-1:0] grad_type;
   typedef logic [GRAD_BITS-1:0]        abs_type;
   typedef logic [PROD_BITS-1:0]        prod_type;

   // where a result's value comes from
   typedef enum logic [1:0] {
      SRC_SUPP,
      SRC_CENTER,
      SRC_UPPER,
      SRC_MID
   } src_type;

endpackage

/* hdl/canny_nonmax_suppression.sv */
// A word's result (if any) reaches rsp_ via the stage 1, 2, 3 and output registers.
// Throughput: one word per cycle; req_ready drops only while rsp_ holds an untaken word.
// Pixels leave in raster order, image_width+1 pixels behind; flush words release the tail.
// Reset (synchronous, active high): width 1024, height 480, counters, window and
// pipeline valids cleared. Line buffers are not cleared; unwritten entries feed borders only.
module canny_nonmax_suppression
   import cnms_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic [MAG_BITS-1:0]      req_magnitude,
   input  logic signed [GRAD_BITS-1:0] req_grad_x,
   input  logic signed [GRAD_BITS-1:0] req_grad_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MAG_BITS-1:0]      rsp_edge_value,
   output logic                     rsp_frame_last,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic                   csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(MAX_WIDTH);
         height_ff <= HEIGHT_BITS'(480);
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_WIDTH:  width_ff  <= csr_pwdata[WIDTH_BITS-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[HEIGHT_BITS-1:0];
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WIDTH: csr_prdata = CSR_DATA_BITS'(width_ff);
         default:   csr_prdata = CSR_DATA_BITS'(height_ff);
      endcase
   end

   // Sizes saturated to the supported range
   logic [WIDTH_BITS-1:0]  wd;
   logic [HEIGHT_BITS-1:0] ht;

   always_comb begin
      if (width_ff < WIDTH_BITS'(MIN_SIZE))
         wd = WIDTH_BITS'(MIN_SIZE);
      else if (width_ff > WIDTH_BITS'(MAX_WIDTH))
         wd = WIDTH_BITS'(MAX_WIDTH);
      else
         wd = width_ff;
      if (height_ff < HEIGHT_BITS'(MIN_SIZE))
         ht = HEIGHT_BITS'(MIN_SIZE);
      else if (height_ff > HEIGHT_BITS'(MAX_HEIGHT))
         ht = HEIGHT_BITS'(MAX_HEIGHT);
      else
         ht = height_ff;
   end

   // ---------------------------------------------------------------
   // Handshake: the whole pipe moves together whenever the output
   // register is empty or being drained. Words without a result
   // travel as bubbles.
   // ---------------------------------------------------------------
   logic adv;
   logic req_fire;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign req_fire  = req_valid && adv;

   // ---------------------------------------------------------------
   // Raster counters and pending flush count
   // ---------------------------------------------------------------
   logic [ADDR_BITS-1:0]   col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [PEND_BITS-1:0]   pend_ff, pend_in;
   logic                   col_last, row_last;
   logic [PEND_BITS-1:0]   pend_full;

   assign col_last  = WIDTH_BITS'(col_ff) == (wd - WIDTH_BITS'(1));
   assign row_last  = row_ff == (ht - HEIGHT_BITS'(1));
   assign pend_full = PEND_BITS'(wd) + PEND_BITS'(1);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (csr_wr) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
      end else if (req_fire) begin
         if (!req_mode) begin
            pend_in = '0;
            if (col_last) begin
               col_in = '0;
               if (row_last) begin
                  row_in  = '0;
                  pend_in = pend_full;
               end else begin
                  row_in = row_ff + HEIGHT_BITS'(1);
               end
            end else begin
               col_in = col_ff + ADDR_BITS'(1);
            end
         end else if (pend_ff != '0) begin
            pend_in = pend_ff - PEND_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: accepted word plus line buffer reads
   // ---------------------------------------------------------------
   logic [ADDR_BITS-1:0] flush_addr, mid_raddr;
   logic                 flush_k0;
   src_type              src_in;
   logic                 out_in;

   // flush k reads middle row entry k-1, k = wd+1-pending
   assign flush_addr = ADDR_BITS'(PEND_BITS'(wd) - pend_ff);
   assign flush_k0   = pend_ff == pend_full;
   assign mid_raddr  = req_mode ? flush_addr : col_ff;

   always_comb begin
      if (req_mode) begin
         out_in = pend_ff != '0;
         src_in = flush_k0 ? SRC_UPPER : SRC_MID;
      end else begin
         // last (right) column of row r-2 goes out first at column 0
         out_in = (col_ff == '0) ? (row_ff >= HEIGHT_BITS'(2)) : (row_ff != '0);
         if (col_ff == '0)
            src_in = SRC_UPPER;
         else if (row_ff == HEIGHT_BITS'(1) || col_ff == ADDR_BITS'(1))
            src_in = SRC_CENTER;
         else
            src_in = SRC_SUPP;
      end
   end

   logic                 s1_pix_ff, s1_out_ff, s1_flast_ff, s1_wlast_ff;
   src_type              s1_src_ff;
   mag_type              s1_g_ff;
   grad_type             s1_gx_ff, s1_gy_ff;
   logic [ADDR_BITS-1:0] s1_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pix_ff <= 1'b0;
         s1_out_ff <= 1'b0;
      end else if (adv) begin
         s1_pix_ff <= req_fire && !req_mode;
         s1_out_ff <= req_fire && out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_src_ff   <= src_in;
         s1_flast_ff <= req_mode && (pend_ff == PEND_BITS'(1));
         s1_wlast_ff <= col_last;
         s1_g_ff     <= req_magnitude;
         s1_gx_ff    <= req_grad_x;
         s1_gy_ff    <= req_grad_y;
         s1_addr_ff  <= col_ff;
      end
   end

   // Line buffers; writes land as the word leaves stage 1, never at the
   // column that the next pixel reads in the same cycle.
   mag_type                         upper_mem [MAX_WIDTH];
   mag_type                         mid_mem   [MAX_WIDTH];
   logic [2*GRAD_BITS-1:0]          grad_mem  [MAX_WIDTH];
   mag_type                         rd_up_ff, rd_mid_ff;
   logic [2*GRAD_BITS-1:0]          rd_grad_ff;
   mag_type                         upper_last_ff;
   logic                            buf_wr;

   assign buf_wr = adv && s1_pix_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_up_ff   <= upper_mem[col_ff];
         rd_mid_ff  <= mid_mem[mid_raddr];
         rd_grad_ff <= grad_mem[col_ff];
      end
      if (buf_wr) begin
         upper_mem[s1_addr_ff] <= rd_mid_ff;
         mid_mem[s1_addr_ff]   <= s1_g_ff;
         grad_mem[s1_addr_ff]  <= {s1_gy_ff, s1_gx_ff};
      end
   end

   // copy of the last upper row entry, needed by the column-0 output
   always_ff @(posedge clock) begin
      if (buf_wr && s1_wlast_ff)
         upper_last_ff <= rd_mid_ff;
   end

   // 3x3 window and centre gradients
   mag_type  win_ff [9];
   mag_type  win_in [9];
   grad_type cgx_ff, cgy_ff;

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = rd_up_ff;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = rd_mid_ff;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s1_g_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++)
            win_ff[i] <= '0;
         cgx_ff <= '0;
         cgy_ff <= '0;
      end else if (buf_wr) begin
         for (int i = 0; i < 9; i++)
            win_ff[i] <= win_in[i];
         cgx_ff <= grad_type'(rd_grad_ff[GRAD_BITS-1:0]);
         cgy_ff <= grad_type'(rd_grad_ff[2*GRAD_BITS-1:GRAD_BITS]);
      end
   end

   // Operand selection. Every case reduces to two tests of the form
   // (g+1)*mx > (mx-mn)*a + mn*b; axis cases use mx=1, mn=0.
   abs_type ax, ay, mx_in, mn_in;
   mag_type a1_in, b1_in, a2_in, b2_in, pass_in;
   logic    same_sign, horiz;

   always_comb begin
      ax = cgx_ff[GRAD_BITS-1] ? abs_type'(-cgx_ff) : abs_type'(cgx_ff);
      ay = cgy_ff[GRAD_BITS-1] ? abs_type'(-cgy_ff) : abs_type'(cgy_ff);
      same_sign = cgx_ff[GRAD_BITS-1] == cgy_ff[GRAD_BITS-1];
      horiz     = ay < ax;
      mx_in = horiz ? ax : ay;
      mn_in = horiz ? ay : ax;
      if (same_sign && horiz) begin
         a1_in = win_in[5]; b1_in = win_in[2]; a2_in = win_in[3]; b2_in = win_in[6];
      end else if (same_sign) begin
         a1_in = win_in[1]; b1_in = win_in[2]; a2_in = win_in[7]; b2_in = win_in[6];
      end else if (horiz) begin
         a1_in = win_in[3]; b1_in = win_in[0]; a2_in = win_in[5]; b2_in = win_in[8];
      end else begin
         a1_in = win_in[1]; b1_in = win_in[0]; a2_in = win_in[7]; b2_in = win_in[8];
      end
      if (cgx_ff == '0) begin
         mx_in = abs_type'(1); mn_in = '0;
         a1_in = win_in[1]; a2_in = win_in[7]; b1_in = '0; b2_in = '0;
      end else if (cgy_ff == '0) begin
         mx_in = abs_type'(1); mn_in = '0;
         a1_in = win_in[3]; a2_in = win_in[5]; b1_in = '0; b2_in = '0;
      end
      case (s1_src_ff)
         SRC_UPPER: pass_in = upper_last_ff;
         SRC_MID:   pass_in = rd_mid_ff;
         default:   pass_in = win_in[4];
      endcase
   end

   // ---------------------------------------------------------------
   // Stage 2: operands
   // ---------------------------------------------------------------
   logic    s2_out_ff, s2_flast_ff;
   src_type s2_src_ff;
   mag_type s2_pass_ff, s2_g_ff, s2_a1_ff, s2_b1_ff, s2_a2_ff, s2_b2_ff;
   abs_type s2_mx_ff, s2_mn_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_out_ff <= 1'b0;
      else if (adv)
         s2_out_ff <= s1_out_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_src_ff   <= s1_src_ff;
         s2_flast_ff <= s1_flast_ff;
         s2_pass_ff  <= pass_in;
         s2_g_ff     <= win_in[4];
         s2_mx_ff    <= mx_in;
         s2_mn_ff    <= mn_in;
         s2_a1_ff    <= a1_in;
         s2_b1_ff    <= b1_in;
         s2_a2_ff    <= a2_in;
         s2_b2_ff    <= b2_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: products
   // ---------------------------------------------------------------
   logic [MAG_BITS:0] g_inc;
   abs_type           diff;

   assign g_inc = {1'b0, s2_g_ff} + (MAG_BITS+1)'(1);
   assign diff  = s2_mx_ff - s2_mn_ff;

   logic     s3_out_ff, s3_flast_ff;
   src_type  s3_src_ff;
   mag_type  s3_pass_ff, s3_g_ff;
   prod_type s3_p0_ff, s3_q1_ff, s3_r1_ff, s3_q2_ff, s3_r2_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s3_out_ff <= 1'b0;
      else if (adv)
         s3_out_ff <= s2_out_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_src_ff   <= s2_src_ff;
         s3_flast_ff <= s2_flast_ff;
         s3_pass_ff  <= s2_pass_ff;
         s3_g_ff     <= s2_g_ff;
         s3_p0_ff    <= PROD_BITS'(g_inc) * PROD_BITS'(s2_mx_ff);
         s3_q1_ff    <= PROD_BITS'(diff) * PROD_BITS'(s2_a1_ff);
         s3_r1_ff    <= PROD_BITS'(s2_mn_ff) * PROD_BITS'(s2_b1_ff);
         s3_q2_ff    <= PROD_BITS'(diff) * PROD_BITS'(s2_a2_ff);
         s3_r2_ff    <= PROD_BITS'(s2_mn_ff) * PROD_BITS'(s2_b2_ff);
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: compare and output register
   // ---------------------------------------------------------------
   logic    keep;
   mag_type edge_in;
   mag_type edge_value_ff;
   logic    frame_last_ff;

   assign keep = (s3_p0_ff > (s3_q1_ff + s3_r1_ff)) && (s3_p0_ff > (s3_q2_ff + s3_r2_ff));

   always_comb begin
      if (s3_src_ff == SRC_SUPP)
         edge_in = keep ? s3_g_ff : '0;
      else
         edge_in = s3_pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv)
         rsp_valid_ff <= s3_out_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         edge_value_ff <= edge_in;
         frame_last_ff <= s3_flast_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = edge_value_ff;
   assign rsp_frame_last = frame_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) pend_ff <= pend_full)
      else $error("pending count above width+1");

   assert property (@(posedge clock) disable iff (reset) WIDTH_BITS'(col_ff) < wd)
      else $error("column counter beyond row width");

   assert property (@(posedge clock) disable iff (reset)
      s1_pix_ff && req_fire && !req_mode |-> s1_addr_ff != col_ff)
      else $error("line buffer read collides with pending write");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_mode && !csr_wr && !(col_last && row_last) |=> pend_ff == '0)
      else $error("pixel word left results pending");
`endif

endmodule
